// ===== src/dws_pkg.sv =====
// shared types and constants for the deque with search
package dws_pkg;

    localparam int DEPTH_DEF = 16;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_SEARCH     = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               found;
        logic [3:0]         match_position;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_DATA,
        ST_SEARCH,
        ST_RESULT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic pop_cap;
        logic srch_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       hit;
        logic       last;
    } stat_t;

endpackage

// ===== src/dws_ram.sv =====
// generic single write port, single read port ram with registered read
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/dws_ctrl.sv =====
// controller state machine for the deque with search
module dws_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  dws_pkg::stat_t stat,
    output dws_pkg::cmd_t  cmd
);

    dws_pkg::ctrl_state_t state_reg;
    dws_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dws_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dws_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = dws_pkg::ST_EXEC;
                end
            end
            dws_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (stat.kind)
                    dws_pkg::KIND_POP_FRONT, dws_pkg::KIND_POP_BACK:
                        state_next = stat.empty ? dws_pkg::ST_RESULT : dws_pkg::ST_POP_DATA;
                    dws_pkg::KIND_SEARCH:
                        state_next = stat.empty ? dws_pkg::ST_RESULT : dws_pkg::ST_SEARCH;
                    default:
                        state_next = dws_pkg::ST_RESULT;
                endcase
            end
            dws_pkg::ST_POP_DATA:
            begin
                cmd.pop_cap = 1'b1;
                state_next  = dws_pkg::ST_RESULT;
            end
            dws_pkg::ST_SEARCH:
            begin
                // one stored entry compared per cycle, front to back
                cmd.srch_step = 1'b1;
                if (stat.hit || stat.last)
                begin
                    state_next = dws_pkg::ST_RESULT;
                end
            end
            dws_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dws_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != dws_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/dws_dp.sv =====
// datapath: ring pointers, entry storage, search walk and result register
module dws_dp #(
    parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dws_pkg::in_item_t   in_data,
    input  dws_pkg::cmd_t       cmd,
    output dws_pkg::stat_t      stat,
    output dws_pkg::out_item_t  out_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W1    = IDX_W + 1;

    dws_pkg::in_item_t  op_reg;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   srch_idx_reg;
    logic [IDX_W-1:0]   srch_idx_next;
    logic [31:0]        popped_reg;
    logic [31:0]        popped_next;
    logic               found_reg;
    logic               found_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    dws_pkg::out_item_t out_reg;

    logic               full;
    logic               empty;
    logic               hit;
    logic               last;
    logic [W1-1:0]      srch_inc;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic               rd_en;
    logic [W1-1:0]      rd_off;
    logic [IDX_W-1:0]   rd_addr;
    logic [31:0]        rd_data;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [W1-1:0] off);
        logic [W1-1:0] s;
        s = W1'(base) + off;
        if (s >= W1'(DEPTH))
        begin
            s = s - W1'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign hit       = (rd_data == op_reg.value);
    assign srch_inc  = W1'(srch_idx_reg) + W1'(1);
    assign last      = (srch_inc == W1'(count_reg));
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    assign stat.kind  = op_reg.kind;
    assign stat.empty = empty;
    assign stat.hit   = hit;
    assign stat.last  = last;

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        srch_idx_next = srch_idx_reg;
        popped_next   = popped_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = front_dec;
        rd_en         = 1'b0;
        rd_off        = '0;

        if (cmd.exec)
        begin
            popped_next   = '0;
            found_next    = 1'b0;
            pos_next      = '0;
            status_next   = dws_pkg::STATUS_OK;
            srch_idx_next = '0;
            unique case (op_reg.kind)
                dws_pkg::KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = dws_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                dws_pkg::KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = dws_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_pos(front_reg, W1'(count_reg));
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                dws_pkg::KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = dws_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_off     = '0;
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                dws_pkg::KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = dws_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_off     = W1'(count_reg) - W1'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                dws_pkg::KIND_SEARCH:
                begin
                    // first entry read here, compared in the next cycle
                    rd_en  = !empty;
                    rd_off = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.pop_cap)
        begin
            popped_next = rd_data;
        end

        if (cmd.srch_step)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                pos_next   = srch_idx_reg;
            end
            else if (!last)
            begin
                // fetch the following entry while this one is compared
                rd_en         = 1'b1;
                rd_off        = srch_inc;
                srch_idx_next = srch_inc[IDX_W-1:0];
            end
        end
    end

    assign rd_addr = ring_pos(front_reg, rd_off);

    dws_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op_reg.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // result fields wrap to their port widths
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_data;
        end
        srch_idx_reg <= srch_idx_next;
        popped_reg   <= popped_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        if (cmd.out_load)
        begin
            out_reg.popped_value   <= popped_reg;
            out_reg.found          <= found_reg;
            out_reg.match_position <= 4'(pos_reg);
            out_reg.entry_count    <= 5'(count_reg);
            out_reg.status         <= status_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== src/deque_with_search.sv =====
// top level of the bounded double-ended queue with linear search
// push and unknown operations pass through the exec and result states; a non-empty pop adds a pop_data step
// search adds one search step per entry up to the match or the last entry, none on an empty queue
// one operation is in work at a time; the next input is taken only after the result is loaded,
// and an output stall holds the result state until the output register is free
// reset clears front index, count and all handshake state; entry ram is not cleared
module deque_with_search #(
    parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dws_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output dws_pkg::out_item_t out_data
);

    dws_pkg::cmd_t  cmd;
    dws_pkg::stat_t stat;

    dws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// ===== verif/deque_checker.sv =====
// checker for the deque with search: predicts each reply and compares it with the block's output
module deque_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  dws_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  dws_pkg::out_item_t out_data,
    output int                 outstanding,
    output int                 errors
);

    localparam int DEPTH = dws_pkg::DEPTH_DEF;

    logic signed [31:0] ring_mem [DEPTH];
    logic [3:0]         head;
    logic [4:0]         fill;
    dws_pkg::out_item_t pending_replies [$];
    int                 reply_no;

    initial
    begin
        head        = '0;
        fill        = '0;
        errors      = 0;
        outstanding = 0;
        reply_no    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("reply %0d: %s got %0h want %0h", reply_no, what, got, want);
        errors++;
    endtask

    // applies one operation to the ring and returns the reply it should give
    function automatic dws_pkg::out_item_t apply_op(input dws_pkg::in_item_t op);
        dws_pkg::out_item_t r;
        r = '0;
        case (op.kind)
            dws_pkg::KIND_PUSH_FRONT:
            begin
                if (fill >= DEPTH)
                    r.status = dws_pkg::STATUS_FULL;
                else
                begin
                    head = 4'((head + DEPTH - 1) % DEPTH);
                    ring_mem[head] = op.value;
                    fill = fill + 1'b1;
                end
            end
            dws_pkg::KIND_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                    r.status = dws_pkg::STATUS_FULL;
                else
                begin
                    ring_mem[4'((head + fill) % DEPTH)] = op.value;
                    fill = fill + 1'b1;
                end
            end
            dws_pkg::KIND_POP_FRONT:
            begin
                if (fill == 0)
                    r.status = dws_pkg::STATUS_EMPTY;
                else
                begin
                    r.popped_value = ring_mem[head];
                    head = 4'((head + 1) % DEPTH);
                    fill = fill - 1'b1;
                end
            end
            dws_pkg::KIND_POP_BACK:
            begin
                if (fill == 0)
                    r.status = dws_pkg::STATUS_EMPTY;
                else
                begin
                    r.popped_value = ring_mem[4'((head + fill - 1) % DEPTH)];
                    fill = fill - 1'b1;
                end
            end
            dws_pkg::KIND_SEARCH:
            begin
                // first match from the front wins
                for (int k = 0; k < fill; k++)
                begin
                    if (!r.found && ring_mem[4'((head + k) % DEPTH)] == op.value)
                    begin
                        r.found = 1'b1;
                        r.match_position = 4'(k);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = fill;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        dws_pkg::out_item_t want;
        dws_pkg::out_item_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch("reply with none pending", out_data.popped_value, '0);
                else
                begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    if (out_data.popped_value !== want.popped_value)
                        report_mismatch("popped_value", out_data.popped_value,
                                        want.popped_value);
                    if (out_data.found !== want.found)
                        report_mismatch("found", 32'(out_data.found), 32'(want.found));
                    if (out_data.match_position !== want.match_position)
                        report_mismatch("match_position", 32'(out_data.match_position),
                                        32'(want.match_position));
                    if (out_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(out_data.entry_count),
                                        32'(want.entry_count));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status), 32'(want.status));
                end
                reply_no++;
            end
            if (in_valid && !in_stall)
            begin
                pred = apply_op(in_data);
                pending_replies.insert(pending_replies.size(), pred);
            end
        end
        outstanding <= pending_replies.size();
    end

endmodule

// ===== verif/tb_deque_with_search.sv =====
// testbench top for the deque with search: clock, reset, operation stimulus and verdict
module tb_deque_with_search;

    localparam int RANDOM_OPS   = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    dws_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    dws_pkg::out_item_t out_data;

    int   outstanding;
    int   errors;
    logic quiet         = 1'b0;
    int   hold_requests = 0;
    int   holds_done    = 0;

    always #6 clk = ~clk;

    deque_with_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    deque_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // offers one operation, with a random gap first unless quiet, and returns once it is transferred
    task automatic send_op(input logic [2:0] kind, input logic [31:0] value);
        if (!quiet)
        begin
            while ($urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind, value: value};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // small values dominate so that searches hit and duplicates show up
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 32'($urandom_range(7));
        else if (sel == 6)
            return ~32'($urandom_range(3));
        else if (sel == 7)
            return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        else
            return $urandom;
    endfunction

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = holds_done + 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 36);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("[deque_with_search] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int push_w;
        int pop_w;
        int r;
        logic [2:0] kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue cases and unused codes
        send_op(dws_pkg::KIND_POP_FRONT, 32'h0);
        send_op(dws_pkg::KIND_POP_BACK, 32'hffffffff);
        send_op(dws_pkg::KIND_SEARCH, 32'h0);
        send_op(3'd5, 32'h12345678);
        send_op(3'd7, 32'hffffffff);
        // extremes at both ends
        send_op(dws_pkg::KIND_PUSH_BACK, 32'h7fffffff);
        send_op(dws_pkg::KIND_PUSH_FRONT, 32'h80000000);
        send_op(dws_pkg::KIND_PUSH_BACK, 32'h0);
        send_op(dws_pkg::KIND_PUSH_FRONT, 32'hffffffff);
        send_op(dws_pkg::KIND_SEARCH, 32'h7fffffff);
        send_op(dws_pkg::KIND_SEARCH, 32'h00012345);
        send_op(dws_pkg::KIND_POP_FRONT, 32'h0);
        send_op(dws_pkg::KIND_POP_BACK, 32'h0);
        // fill up with duplicates, then push while full
        for (int i = 0; i < 14; i++)
            send_op(dws_pkg::KIND_PUSH_BACK, (i == 13) ? 32'h5555aaaa : 32'(i % 4));
        send_op(dws_pkg::KIND_PUSH_FRONT, 32'h1);
        send_op(dws_pkg::KIND_PUSH_BACK, 32'h2);
        send_op(dws_pkg::KIND_SEARCH, 32'h2);
        send_op(dws_pkg::KIND_SEARCH, 32'h5555aaaa);

        mode = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 40 == 0)
                mode = $urandom_range(2);
            if (n == 300)
                hold_requests <= hold_requests + 1;
            if (n == 500)
                quiet <= 1'b1;
            if (n == 700)
                quiet <= 1'b0;
            if (n == 900)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            case (mode)
                0:       begin push_w = 60; pop_w = 15; end
                1:       begin push_w = 15; pop_w = 60; end
                default: begin push_w = 35; pop_w = 30; end
            endcase
            r = $urandom_range(99);
            if (r < 3)
                kind = 3'($urandom_range(7, 5));
            else if (r < 3 + push_w)
                kind = $urandom_range(1) ? dws_pkg::KIND_PUSH_FRONT : dws_pkg::KIND_PUSH_BACK;
            else if (r < 3 + push_w + pop_w)
                kind = $urandom_range(1) ? dws_pkg::KIND_POP_FRONT : dws_pkg::KIND_POP_BACK;
            else
                kind = dws_pkg::KIND_SEARCH;
            send_op(kind, pick_value());
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (dws_pkg::DEPTH_DEF + 8) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("[deque_with_search] OK");
        else
            $display("[deque_with_search] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/dws_pkg.sv
src/dws_ram.sv
src/dws_ctrl.sv
src/dws_dp.sv
src/deque_with_search.sv
verif/deque_checker.sv
verif/tb_deque_with_search.sv
